// ----- rtl/core/lsc_pkg.sv -----
// shared constants and register index codes for the line segment clipper
package lsc_pkg;

  // configuration register index
  typedef enum logic [1:0] {
    REG_LEFT   = 2'd0,
    REG_BOTTOM = 2'd1,
    REG_RIGHT  = 2'd2,
    REG_TOP    = 2'd3
  } reg_idx_t;

  // window edges handled in parallel
  localparam int NUM_EDGES = 4;

  // window reset values
  localparam int LEFT_RST   = 10;
  localparam int BOTTOM_RST = 10;
  localparam int RIGHT_RST  = 100;
  localparam int TOP_RST    = 100;

endpackage

// ----- rtl/core/lsc_seg_if.sv -----
// segment request channel
interface lsc_seg_if #(
  parameter int COORD_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

// ----- rtl/core/lsc_clip_if.sv -----
// clipped segment result channel
interface lsc_clip_if #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) ();
  logic                         valid;
  logic                         ready;
  logic                         visible;
  logic signed [COORD_BITS-1:0] clip_start_x;
  logic signed [COORD_BITS-1:0] clip_start_y;
  logic signed [COORD_BITS-1:0] clip_end_x;
  logic signed [COORD_BITS-1:0] clip_end_y;
  logic [FRAC_BITS:0]           enter_param;
  logic [FRAC_BITS:0]           leave_param;

  modport source (output valid, visible, clip_start_x, clip_start_y, clip_end_x,
                  clip_end_y, enter_param, leave_param, input ready);
  modport sink (input valid, visible, clip_start_x, clip_start_y, clip_end_x,
                clip_end_y, enter_param, leave_param, output ready);
endinterface

// ----- rtl/core/lsc_cfg_if.sv -----
// configuration write channel
interface lsc_cfg_if #(
  parameter int COORD_BITS = 16
) ();
  logic                   valid;
  logic                   ready;
  lsc_pkg::reg_idx_t      index;
  logic [COORD_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/line_segment_clipper.sv -----
// a segment request passes setup, the divider chain, resolve, the product stage and the output register
// throughput: one segment per cycle while the result channel is not held; each divider cell yields one quotient bit
// of the left, right, bottom and top edge ratios, so the chain has FRAC_BITS + 2 cells
// every stage stalls only when the stage after it is full and held
// reset (rst, synchronous): all stages empty, window 10..100 in x and y
module line_segment_clipper #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic       clk,
  input  logic       rst,
  lsc_cfg_if.sink    cfg,
  lsc_seg_if.sink    seg,
  lsc_clip_if.source clip
);
  import lsc_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int DW = COORD_BITS + 1;
  localparam int RW = COORD_BITS + 3;
  localparam int QW = FRAC_BITS + 2;

  typedef struct packed {
    logic signed [CW-1:0]  x1;
    logic signed [CW-1:0]  y1;
    logic signed [DW-1:0]  dx;
    logic signed [DW-1:0]  dy;
    logic [NUM_EDGES-1:0]  pzero;
    logic [NUM_EDGES-1:0]  rneg;
    logic [NUM_EDGES-1:0]  sat;
    logic                  par_rej;
  } side_t;

  logic signed [CW-1:0] win_left, win_bottom, win_right, win_top;

  logic [QW:0]                  c_valid;
  logic [QW:0]                  c_ready;
  logic [3:0][RW-1:0]           c_rem  [QW+1];
  logic [3:0][RW-1:0]           c_div  [QW+1];
  logic [3:0][QW-1:0]           c_quo  [QW+1];
  side_t                        c_side [QW+1];

  logic                         r_valid, r_ready, r_visible;
  logic [FRAC_BITS:0]           r_enter, r_leave;
  logic signed [CW-1:0]         r_x1, r_y1;
  logic signed [DW-1:0]         r_dx, r_dy;

  // window registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_left   <= CW'(LEFT_RST);
      win_bottom <= CW'(BOTTOM_RST);
      win_right  <= CW'(RIGHT_RST);
      win_top    <= CW'(TOP_RST);
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_LEFT:   win_left   <= cfg.data;
        REG_BOTTOM: win_bottom <= cfg.data;
        REG_RIGHT:  win_right  <= cfg.data;
        REG_TOP:    win_top    <= cfg.data;
        default: ;
      endcase
    end
  end

  // edge setup
  lsc_setup #(
    .COORD_BITS (COORD_BITS),
    .RW         (RW),
    .side_t     (side_t)
  ) u_setup (
    .clk        (clk),
    .rst        (rst),
    .seg        (seg),
    .win_left   (win_left),
    .win_bottom (win_bottom),
    .win_right  (win_right),
    .win_top    (win_top),
    .out_valid  (c_valid[0]),
    .out_ready  (c_ready[0]),
    .out_rem    (c_rem[0]),
    .out_div    (c_div[0]),
    .out_side   (c_side[0])
  );

  assign c_quo[0] = '0;

  // divider chain, most significant quotient bit first
  for (genvar k = 0; k < QW; k++) begin : g_cell
    lsc_div_cell #(
      .RW     (RW),
      .QW     (QW),
      .side_t (side_t)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (c_valid[k]),
      .in_ready  (c_ready[k]),
      .in_rem    (c_rem[k]),
      .in_div    (c_div[k]),
      .in_quo    (c_quo[k]),
      .in_side   (c_side[k]),
      .out_valid (c_valid[k+1]),
      .out_ready (c_ready[k+1]),
      .out_rem   (c_rem[k+1]),
      .out_div   (c_div[k+1]),
      .out_quo   (c_quo[k+1]),
      .out_side  (c_side[k+1])
    );
  end

  // clamp and fold
  lsc_resolve #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .side_t     (side_t)
  ) u_resolve (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (c_valid[QW]),
    .in_ready    (c_ready[QW]),
    .in_quo      (c_quo[QW]),
    .in_side     (c_side[QW]),
    .out_valid   (r_valid),
    .out_ready   (r_ready),
    .out_visible (r_visible),
    .out_enter   (r_enter),
    .out_leave   (r_leave),
    .out_x1      (r_x1),
    .out_y1      (r_y1),
    .out_dx      (r_dx),
    .out_dy      (r_dy)
  );

  // endpoint interpolation and output register
  lsc_interp #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_interp (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (r_valid),
    .in_ready   (r_ready),
    .in_visible (r_visible),
    .in_enter   (r_enter),
    .in_leave   (r_leave),
    .in_x1      (r_x1),
    .in_y1      (r_y1),
    .in_dx      (r_dx),
    .in_dy      (r_dy),
    .clip       (clip)
  );

endmodule

// ----- rtl/core/lsc_setup.sv -----
// edge setup stage: forms p and q per edge and seeds the divider chain
module lsc_setup #(
  parameter int COORD_BITS = 16,
  parameter int RW         = 19,
  parameter type side_t    = logic
) (
  input  logic                         clk,
  input  logic                         rst,
  lsc_seg_if.sink                      seg,
  input  logic signed [COORD_BITS-1:0] win_left,
  input  logic signed [COORD_BITS-1:0] win_bottom,
  input  logic signed [COORD_BITS-1:0] win_right,
  input  logic signed [COORD_BITS-1:0] win_top,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [3:0][RW-1:0]           out_rem,
  output logic [3:0][RW-1:0]           out_div,
  output side_t                        out_side
);
  import lsc_pkg::*;

  localparam int DW = COORD_BITS + 1;

  logic signed [DW-1:0] dx, dy;
  logic signed [DW-1:0] p [NUM_EDGES];
  logic signed [DW-1:0] q [NUM_EDGES];
  logic [NUM_EDGES-1:0][RW-1:0] rem_next, div_next;
  side_t side_next;

  // deltas, p and q for the left, right, bottom and top edges
  always_comb begin
    dx   = DW'(seg.end_x) - DW'(seg.start_x);
    dy   = DW'(seg.end_y) - DW'(seg.start_y);
    p[0] = -dx;
    q[0] = DW'(seg.start_x) - DW'(win_left);
    p[1] = dx;
    q[1] = DW'(win_right) - DW'(seg.start_x);
    p[2] = -dy;
    q[2] = DW'(seg.start_y) - DW'(win_bottom);
    p[3] = dy;
    q[3] = DW'(win_top) - DW'(seg.start_y);
  end

  // magnitudes, divisor scaled by four, saturation and sign flags
  always_comb begin
    logic [DW-1:0] pm, qm;
    side_next         = '0;
    side_next.x1      = seg.start_x;
    side_next.y1      = seg.start_y;
    side_next.dx      = dx;
    side_next.dy      = dy;
    side_next.par_rej = 1'b0;
    for (int i = 0; i < NUM_EDGES; i++) begin
      pm = p[i][DW-1] ? DW'(-p[i]) : p[i];
      qm = q[i][DW-1] ? DW'(-q[i]) : q[i];
      div_next[i] = RW'(pm) << 2;
      rem_next[i] = RW'(qm);
      side_next.pzero[i] = (p[i] == '0);
      side_next.rneg[i]  = p[i][DW-1] ^ q[i][DW-1];
      side_next.sat[i]   = (RW'(qm) >= (RW'(pm) << 2));
      if ((p[i] == '0) && q[i][DW-1]) begin
        side_next.par_rej = 1'b1;
      end
    end
  end

  assign seg.ready = !out_valid || out_ready;

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (seg.ready) begin
      out_valid <= seg.valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (seg.valid && seg.ready) begin
      out_rem  <= rem_next;
      out_div  <= div_next;
      out_side <= side_next;
    end
  end

endmodule

// ----- rtl/core/lsc_div_cell.sv -----
// one restoring divide step for each of the left, right, bottom and top edges, one quotient bit per cell
module lsc_div_cell #(
  parameter int RW      = 19,
  parameter int QW      = 18,
  parameter type side_t = logic
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0][RW-1:0] in_rem,
  input  logic [3:0][RW-1:0] in_div,
  input  logic [3:0][QW-1:0] in_quo,
  input  side_t              in_side,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0][RW-1:0] out_rem,
  output logic [3:0][RW-1:0] out_div,
  output logic [3:0][QW-1:0] out_quo,
  output side_t              out_side
);
  import lsc_pkg::*;

  logic [NUM_EDGES-1:0][RW-1:0] rem_next;
  logic [NUM_EDGES-1:0][QW-1:0] quo_next;

  // shift, trial subtract, keep on no borrow
  always_comb begin
    logic [RW-1:0] sh;
    logic          ge;
    for (int i = 0; i < NUM_EDGES; i++) begin
      sh          = in_rem[i] << 1;
      ge          = (sh >= in_div[i]);
      rem_next[i] = ge ? (sh - in_div[i]) : sh;
      quo_next[i] = {in_quo[i][QW-2:0], ge};
    end
  end

  assign in_ready = !out_valid || out_ready;

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_rem  <= rem_next;
      out_div  <= in_div;
      out_quo  <= quo_next;
      out_side <= in_side;
    end
  end

endmodule

// ----- rtl/core/lsc_resolve.sv -----
// clamps the edge ratios and folds them into the enter and leave parameters
module lsc_resolve #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16,
  parameter type side_t    = logic
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [3:0][FRAC_BITS+1:0]    in_quo,
  input  side_t                        in_side,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_visible,
  output logic [FRAC_BITS:0]           out_enter,
  output logic [FRAC_BITS:0]           out_leave,
  output logic signed [COORD_BITS-1:0] out_x1,
  output logic signed [COORD_BITS-1:0] out_y1,
  output logic signed [COORD_BITS:0]   out_dx,
  output logic signed [COORD_BITS:0]   out_dy
);
  import lsc_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int TW = FRAC_BITS + 3;
  localparam logic signed [TW-1:0] T_ONE   = TW'(1) << FRAC_BITS;
  localparam logic signed [TW-1:0] T_MAX   = T_ONE + TW'(1);
  localparam logic signed [TW-1:0] T_MINUS = '1;

  logic signed [TW-1:0] r [NUM_EDGES];
  logic [NUM_EDGES-1:0] pneg;
  logic signed [TW-1:0] te, tl;
  logic                 ok;

  // clamped ratio and entering flag per edge
  always_comb begin
    logic signed [DW-1:0] d;
    for (int i = 0; i < NUM_EDGES; i++) begin
      d = (i < 2) ? in_side.dx : in_side.dy;
      // even edges use p = -d, odd edges p = d
      pneg[i] = ((i % 2) == 0) ? (!d[DW-1] && (d != '0)) : d[DW-1];
      if (in_side.rneg[i]) begin
        r[i] = (in_side.sat[i] || (in_quo[i] != '0)) ? T_MINUS : '0;
      end else if (in_side.sat[i] || ($signed(TW'(in_quo[i])) > T_MAX)) begin
        r[i] = T_MAX;
      end else begin
        r[i] = TW'(in_quo[i]);
      end
    end
  end

  // raise enter, lower leave
  always_comb begin
    te = '0;
    tl = T_ONE;
    for (int i = 0; i < NUM_EDGES; i++) begin
      if (!in_side.pzero[i]) begin
        if (pneg[i]) begin
          if (r[i] > te) te = r[i];
        end else begin
          if (r[i] < tl) tl = r[i];
        end
      end
    end
    ok = !in_side.par_rej && (te <= tl);
  end

  assign in_ready = !out_valid || out_ready;

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // stage payload, params zeroed on reject
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_visible <= ok;
      out_enter   <= ok ? te[FRAC_BITS:0] : '0;
      out_leave   <= ok ? tl[FRAC_BITS:0] : '0;
      out_x1      <= in_side.x1;
      out_y1      <= in_side.y1;
      out_dx      <= in_side.dx;
      out_dy      <= in_side.dy;
    end
  end

endmodule

// ----- rtl/core/lsc_interp.sv -----
// interpolation: product stage, then rounding add into the output register
module lsc_interp #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_visible,
  input  logic [FRAC_BITS:0]           in_enter,
  input  logic [FRAC_BITS:0]           in_leave,
  input  logic signed [COORD_BITS-1:0] in_x1,
  input  logic signed [COORD_BITS-1:0] in_y1,
  input  logic signed [COORD_BITS:0]   in_dx,
  input  logic signed [COORD_BITS:0]   in_dy,
  lsc_clip_if.source                   clip
);
  import lsc_pkg::*;

  localparam int PW = FRAC_BITS + COORD_BITS + 3;
  localparam logic signed [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

  logic                         m_valid;
  logic                         m_ready;
  logic                         o_ready;
  logic                         m_visible;
  logic [FRAC_BITS:0]           m_enter, m_leave;
  logic signed [COORD_BITS-1:0] m_x1, m_y1;
  logic signed [PW-1:0]         m_sx, m_sy, m_ex, m_ey;
  logic signed [FRAC_BITS+1:0]  te_s, tl_s;
  logic signed [PW-1:0]         sx_sh, sy_sh, ex_sh, ey_sh;

  assign te_s = $signed({1'b0, in_enter});
  assign tl_s = $signed({1'b0, in_leave});

  assign o_ready  = !clip.valid || clip.ready;
  assign m_ready  = !m_valid || o_ready;
  assign in_ready = m_ready;

  // product stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (m_ready) begin
      m_valid <= in_valid;
    end
  end

  // t times delta for both ends
  always_ff @(posedge clk) begin
    if (in_valid && m_ready) begin
      m_visible <= in_visible;
      m_enter   <= in_enter;
      m_leave   <= in_leave;
      m_x1      <= in_x1;
      m_y1      <= in_y1;
      m_sx      <= PW'(te_s) * PW'(in_dx);
      m_sy      <= PW'(te_s) * PW'(in_dy);
      m_ex      <= PW'(tl_s) * PW'(in_dx);
      m_ey      <= PW'(tl_s) * PW'(in_dy);
    end
  end

  // round half up, then floor by the fraction width
  assign sx_sh = (m_sx + HALF) >>> FRAC_BITS;
  assign sy_sh = (m_sy + HALF) >>> FRAC_BITS;
  assign ex_sh = (m_ex + HALF) >>> FRAC_BITS;
  assign ey_sh = (m_ey + HALF) >>> FRAC_BITS;

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      clip.valid <= 1'b0;
    end else if (o_ready) begin
      clip.valid <= m_valid;
    end
  end

  // output register payload, zero coordinates on reject
  always_ff @(posedge clk) begin
    if (m_valid && o_ready) begin
      clip.visible      <= m_visible;
      clip.enter_param  <= m_enter;
      clip.leave_param  <= m_leave;
      clip.clip_start_x <= m_visible ? (m_x1 + sx_sh[COORD_BITS-1:0]) : '0;
      clip.clip_start_y <= m_visible ? (m_y1 + sy_sh[COORD_BITS-1:0]) : '0;
      clip.clip_end_x   <= m_visible ? (m_x1 + ex_sh[COORD_BITS-1:0]) : '0;
      clip.clip_end_y   <= m_visible ? (m_y1 + ey_sh[COORD_BITS-1:0]) : '0;
    end
  end

endmodule

// ----- rtl/core/lsc_checker.sv -----
// port-level checks on the clipper result channel, bound to the top level
module lsc_checker #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  clip_valid,
  input logic                  clip_ready,
  input logic                  visible,
  input logic [COORD_BITS-1:0] clip_start_x,
  input logic [COORD_BITS-1:0] clip_start_y,
  input logic [COORD_BITS-1:0] clip_end_x,
  input logic [COORD_BITS-1:0] clip_end_y,
  input logic [FRAC_BITS:0]    enter_param,
  input logic [FRAC_BITS:0]    leave_param
);
  localparam logic [FRAC_BITS:0] T_ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !clip_valid)
    else $error("result valid right after reset");

  // held result keeps its visible flag, x coordinates and enter param
  a_hold: assert property (@(posedge clk) disable iff (rst)
    clip_valid && !clip_ready |=> clip_valid && $stable(visible) &&
      $stable(clip_start_x) && $stable(clip_end_x) && $stable(enter_param))
    else $error("stalled result changed");

  // rejected segment gives all zero fields
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    clip_valid && !visible |-> clip_start_x == '0 && clip_start_y == '0 &&
      clip_end_x == '0 && clip_end_y == '0 && enter_param == '0 &&
      leave_param == '0)
    else $error("rejected segment with nonzero fields");

  // visible segment has ordered params within one
  a_param_order: assert property (@(posedge clk) disable iff (rst)
    clip_valid && visible |-> enter_param <= leave_param && leave_param <= T_ONE)
    else $error("enter/leave params out of order");

endmodule

bind line_segment_clipper lsc_checker #(
  .COORD_BITS (COORD_BITS),
  .FRAC_BITS  (FRAC_BITS)
) u_lsc_checker (
  .clk          (clk),
  .rst          (rst),
  .clip_valid   (clip.valid),
  .clip_ready   (clip.ready),
  .visible      (clip.visible),
  .clip_start_x (clip.clip_start_x),
  .clip_start_y (clip.clip_start_y),
  .clip_end_x   (clip.clip_end_x),
  .clip_end_y   (clip.clip_end_y),
  .enter_param  (clip.enter_param),
  .leave_param  (clip.leave_param)
);
